// ===== design/dcp_pkg.sv =====
// package: shared types, constants and lookup tables of the domain colouring pixel unit
`default_nettype none
package dcp_pkg;

    localparam int LUT_ADDR_BITS = 8;
    localparam int LUT_N = 1 << LUT_ADDR_BITS;
    localparam int EXP_SH = 16 - LUT_ADDR_BITS;
    localparam int LN_SH = 31 - LUT_ADDR_BITS;
    localparam logic [63:0] Q30_ONE = 64'd1 << 30;
    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    localparam logic signed [31:0] LN2_Q16 = 32'sd45426;
    localparam logic [15:0] SHADE_BASE = 16'd52429;
    localparam logic [13:0] SHADE_SPAN = 14'd13107;
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    localparam int PADDR_W = 3;
    localparam logic REG_CONTOUR_SEL = 1'b0;
    localparam logic REG_INV_DENSITY = 1'b1;
    localparam logic [1:0] CONTOUR_SEL_RESET = 2'd0;
    localparam logic [31:0] INV_DENSITY_RESET = 32'd65536;

    typedef logic [16:0] tab_t [0:LUT_N];

    typedef struct packed {
        logic signed [15:0] phase_turns;
        logic [31:0]        magnitude;
    } sample_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_t;

    typedef struct packed {
        logic [1:0]  contour_sel;
        logic [31:0] inv_density;
    } cfg_t;

    function automatic logic [16:0] q30_to_q16(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd8192) >> 14;
        return r[16:0];
    endfunction

    // restoring long division, used only while building the tables
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], num[b]};
            if (r >= {1'b0, den})
            begin
                r = r - {1'b0, den};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic tab_t build_exp2();
        tab_t        tab;
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        for (int k = 0; k <= LUT_N; k++)
        begin
            x = (64'(k) * LN2_Q30) >> LUT_ADDR_BITS;
            term = Q30_ONE;
            sum = Q30_ONE;
            for (int n = 1; n <= 20; n++)
            begin
                term = udiv64((term * x) >> 30, 64'(n));
                if ((n & 1) == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
            tab[k] = q30_to_q16(sum);
        end
        return tab;
    endfunction

    function automatic tab_t build_ln();
        tab_t        tab;
        logic [63:0] u;
        logic [63:0] u2;
        logic [63:0] t;
        logic [63:0] s;
        for (int k = 0; k <= LUT_N; k++)
        begin
            u = udiv64(64'(k) << 30, 64'(2 * LUT_N) + 64'(k));
            u2 = (u * u) >> 30;
            t = u;
            s = u;
            for (int n = 3; n <= 41; n += 2)
            begin
                t = (t * u2) >> 30;
                s = s + udiv64(t, 64'(n));
            end
            tab[k] = q30_to_q16(s << 1);
        end
        return tab;
    endfunction

    localparam tab_t EXP2_TAB = build_exp2();
    localparam tab_t LN_TAB = build_ln();

endpackage
`default_nettype wire

// ===== design/domain_coloring_pixel_unit.sv =====
// top level: domain colouring pixel unit with register port
//
//  channel  direction  word                        handshake
//  sample   in         phase_turns, magnitude      sample_valid / sample_stall
//  color    out        red, green, blue            color_valid / color_stall
//  apb      in/out     contour_sel, inv_density    psel / penable / pready
//
//  one word per cycle unless the output is held; words pass in order through
//  the interpolation, shift and multiplier stages
//  rst_n clears the valid bits and resets the registers, no clearing pass
//  stages fill bubbles while the output is held; input stalls only when all are full
`default_nettype none
module domain_coloring_pixel_unit (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      sample_valid,
    input  wire dcp_pkg::sample_t          sample,
    output logic                           sample_stall,
    output logic                           color_valid,
    output dcp_pkg::color_t                color,
    input  wire logic                      color_stall,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [dcp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import dcp_pkg::*;

    logic [1:0]  mode_reg;
    logic [31:0] dens_reg;
    logic        wr;
    cfg_t        cfg;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= CONTOUR_SEL_RESET;
            dens_reg <= INV_DENSITY_RESET;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[2])
                REG_CONTOUR_SEL: mode_reg <= pwdata[1:0];
                REG_INV_DENSITY: dens_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_CONTOUR_SEL: prdata = {30'b0, mode_reg};
            REG_INV_DENSITY: prdata = dens_reg;
            default:         prdata = '0;
        endcase
    end

    assign cfg.contour_sel = mode_reg;
    assign cfg.inv_density = dens_reg;

    dcp_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .sample_valid (sample_valid),
        .sample       (sample),
        .sample_stall (sample_stall),
        .color_valid  (color_valid),
        .color        (color),
        .color_stall  (color_stall)
    );

endmodule
`default_nettype wire

// ===== design/dcp_core.sv =====
// module: twelve-stage shading pipeline from phase and magnitude to rgb
`default_nettype none
module dcp_core (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dcp_pkg::cfg_t   cfg,
    input  wire logic            sample_valid,
    input  wire dcp_pkg::sample_t sample,
    output logic                 sample_stall,
    output logic                 color_valid,
    output dcp_pkg::color_t      color,
    input  wire logic            color_stall
);
    import dcp_pkg::*;

    localparam int NS = 12;

    logic [NS:1] vld_reg;
    logic [NS:1] en;

    // stage data
    logic [15:0] ph1_reg, ph2_reg, ph3_reg, ph4_reg, ph5_reg, ph6_reg, ph7_reg;
    logic [31:0] mag1_reg, mag2_reg;
    logic [4:0]  msb2_reg, msb3_reg, msb4_reg;
    logic        zero2_reg, zero3_reg, zero4_reg, zero5_reg, zero6_reg, zero7_reg;
    logic        zero8_reg, zero9_reg, zero10_reg, zero11_reg;
    logic [16:0] ea2_reg, eb2_reg, e2_3_reg;
    logic [EXP_SH-1:0] t2_reg;
    logic [15:0] ip2_reg, ip3_reg;
    logic [30:0] mant3_reg;
    logic [16:0] v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg, v10_reg;
    logic [16:0] la4_reg, lb4_reg, lv5_reg;
    logic [LN_SH-1:0] lt4_reg;
    logic [31:0] em5_reg, lnq6_reg;
    logic [15:0] fm7_reg, fac8_reg, facp8_reg, facp9_reg;
    logic [2:0]  sec2_reg, sec3_reg, sec4_reg, sec5_reg, sec6_reg, sec7_reg, sec8_reg;
    logic [2:0]  sec9_reg, sec10_reg, sec11_reg;
    logic [16:0] w2_reg, w3_reg, w4_reg, w5_reg, w6_reg, w7_reg, w8_reg, w9_reg, w10_reg;
    logic [7:0]  cb11_reg;
    logic [16:0] xq11_reg;
    color_t      color_reg;

    // handshake enables
    always_comb
    begin
        en[NS] = !vld_reg[NS] || !color_stall;
        for (int k = NS - 1; k >= 1; k--)
            en[k] = !vld_reg[k] || en[k+1];
    end

    assign sample_stall = !en[1];
    assign color_valid = vld_reg[NS];
    assign color = color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (en[1])
                vld_reg[1] <= sample_valid;
            for (int k = 2; k <= NS; k++)
                if (en[k])
                    vld_reg[k] <= vld_reg[k-1];
        end
    end

    // stage 2 logic: leading one, exp2 lookup, hue sector
    logic [4:0]  msb_next;
    logic [LUT_ADDR_BITS-1:0] ei;
    logic [LUT_ADDR_BITS:0]   ei1;
    logic [18:0] seg;
    always_comb
    begin
        msb_next = '0;
        for (int b = 0; b < 32; b++)
            if (mag1_reg[b])
                msb_next = 5'(b);
        ei = mag1_reg[15:EXP_SH];
        ei1 = {1'b0, ei} + 1'b1;
        seg = {3'b0, ph1_reg} * 19'd6;
    end

    // stage 3 logic: interpolation and normalising shift
    logic [16:0]        ediff;
    logic [16+EXP_SH:0] eprod;
    logic [31:0]        mshift;
    always_comb
    begin
        ediff = ea2_reg - eb2_reg;
        eprod = ediff * t2_reg;
        mshift = mag2_reg << (5'd31 - msb2_reg);
    end

    // stage 4 logic: luminance, ln lookup
    logic [16:0] pw;
    logic [LUT_ADDR_BITS-1:0] li;
    logic [LUT_ADDR_BITS:0]   li1;
    always_comb
    begin
        pw = (|ip3_reg[15:5]) ? 17'd0 : (e2_3_reg >> ip3_reg[4:0]);
        li = mant3_reg[30:LN_SH];
        li1 = {1'b0, li} + 1'b1;
    end

    // stage 5 logic: ln interpolation, exponent term
    logic [16:0]       ldiff;
    logic [16+LN_SH:0] lprod;
    logic signed [31:0] msb_s;
    always_comb
    begin
        ldiff = lb4_reg - la4_reg;
        lprod = ldiff * lt4_reg;
        msb_s = $signed({27'b0, msb4_reg}) - 32'sd16;
    end

    // stage 7 and 8 logic: contour fractions and factors
    logic [31:0] dprod;
    logic [29:0] sprod;
    logic [15:0] pfrac;
    logic [29:0] pprod;
    always_comb
    begin
        dprod = lnq6_reg * cfg.inv_density;
        sprod = fm7_reg * SHADE_SPAN;
        pfrac = 16'(ph7_reg * 16'd12);
        pprod = pfrac * SHADE_SPAN;
    end

    // stage 9 to 12 logic: shading and colour
    logic [32:0] m9;
    logic [32:0] m10;
    logic [24:0] cprod;
    logic [33:0] xprod;
    logic [24:0] xbprod;
    logic [7:0]  xb;
    color_t      col;
    always_comb
    begin
        m9 = v8_reg * fac8_reg;
        m10 = v9_reg * facp9_reg;
        cprod = v10_reg * 8'd255;
        xprod = v10_reg * w10_reg;
        xbprod = xq11_reg * 8'd255;
        xb = xbprod[23:16];
        col = '0;
        case (sec11_reg)
            3'd0: begin col.red = cb11_reg; col.green = xb; end
            3'd1: begin col.red = xb; col.green = cb11_reg; end
            3'd2: begin col.green = cb11_reg; col.blue = xb; end
            3'd3: begin col.green = xb; col.blue = cb11_reg; end
            3'd4: begin col.red = xb; col.blue = cb11_reg; end
            default: begin col.red = cb11_reg; col.blue = xb; end
        endcase
        if (zero11_reg)
            col = '0;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ph1_reg <= sample.phase_turns;
            mag1_reg <= sample.magnitude;
        end
        if (en[2])
        begin
            ph2_reg <= ph1_reg;
            mag2_reg <= mag1_reg;
            msb2_reg <= msb_next;
            zero2_reg <= (mag1_reg == 32'd0);
            ea2_reg <= EXP2_TAB[ei];
            eb2_reg <= EXP2_TAB[ei1];
            t2_reg <= mag1_reg[EXP_SH-1:0];
            ip2_reg <= mag1_reg[31:16];
            sec2_reg <= seg[18:16];
            w2_reg <= seg[16] ? (ONE_Q16 - {1'b0, seg[15:0]}) : {1'b0, seg[15:0]};
        end
        if (en[3])
        begin
            ph3_reg <= ph2_reg;
            e2_3_reg <= ea2_reg - 17'(eprod >> EXP_SH);
            mant3_reg <= mshift[30:0];
            ip3_reg <= ip2_reg;
            msb3_reg <= msb2_reg;
            zero3_reg <= zero2_reg;
            sec3_reg <= sec2_reg;
            w3_reg <= w2_reg;
        end
        if (en[4])
        begin
            ph4_reg <= ph3_reg;
            v4_reg <= ONE_Q16 - pw;
            la4_reg <= LN_TAB[li];
            lb4_reg <= LN_TAB[li1];
            lt4_reg <= mant3_reg[LN_SH-1:0];
            msb4_reg <= msb3_reg;
            zero4_reg <= zero3_reg;
            sec4_reg <= sec3_reg;
            w4_reg <= w3_reg;
        end
        if (en[5])
        begin
            ph5_reg <= ph4_reg;
            v5_reg <= v4_reg;
            lv5_reg <= la4_reg + 17'(lprod >> LN_SH);
            em5_reg <= 32'(msb_s * LN2_Q16);
            zero5_reg <= zero4_reg;
            sec5_reg <= sec4_reg;
            w5_reg <= w4_reg;
        end
        if (en[6])
        begin
            ph6_reg <= ph5_reg;
            v6_reg <= v5_reg;
            lnq6_reg <= em5_reg + {15'b0, lv5_reg};
            zero6_reg <= zero5_reg;
            sec6_reg <= sec5_reg;
            w6_reg <= w5_reg;
        end
        if (en[7])
        begin
            ph7_reg <= ph6_reg;
            v7_reg <= v6_reg;
            fm7_reg <= dprod[31:16];
            zero7_reg <= zero6_reg;
            sec7_reg <= sec6_reg;
            w7_reg <= w6_reg;
        end
        if (en[8])
        begin
            v8_reg <= v7_reg;
            fac8_reg <= SHADE_BASE + {2'b0, sprod[29:16]};
            facp8_reg <= SHADE_BASE + {2'b0, pprod[29:16]};
            zero8_reg <= zero7_reg;
            sec8_reg <= sec7_reg;
            w8_reg <= w7_reg;
        end
        if (en[9])
        begin
            v9_reg <= cfg.contour_sel[0] ? m9[32:16] : v8_reg;
            facp9_reg <= facp8_reg;
            zero9_reg <= zero8_reg;
            sec9_reg <= sec8_reg;
            w9_reg <= w8_reg;
        end
        if (en[10])
        begin
            v10_reg <= cfg.contour_sel[1] ? m10[32:16] : v9_reg;
            zero10_reg <= zero9_reg;
            sec10_reg <= sec9_reg;
            w10_reg <= w9_reg;
        end
        if (en[11])
        begin
            cb11_reg <= cprod[23:16];
            xq11_reg <= xprod[32:16];
            zero11_reg <= zero10_reg;
            sec11_reg <= sec10_reg;
        end
        if (en[12])
            color_reg <= col;
    end

endmodule
`default_nettype wire

// ===== design/dcp_checker.sv =====
// checker: port-level assertions for the domain colouring pixel unit, with bind
`default_nettype none
module dcp_checker (
    input wire logic            clk,
    input wire logic            rst_n,
    input wire logic            sample_stall,
    input wire logic            color_valid,
    input wire dcp_pkg::color_t color,
    input wire logic            color_stall,
    input wire logic            pready
);
    import dcp_pkg::*;

    // input only backs up when the output word is held
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (color_valid && color_stall))
        else $error("input stalled without a held output word");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (color_valid && color_stall) |=> (color_valid && $stable(color)))
        else $error("held output word changed");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

    a_reset_empty: assert property (@(posedge clk)
        $rose(rst_n) |-> !color_valid)
        else $error("output word valid straight after reset");

endmodule

bind domain_coloring_pixel_unit dcp_checker u_dcp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_stall (sample_stall),
    .color_valid  (color_valid),
    .color        (color),
    .color_stall  (color_stall),
    .pready       (pready)
);
`default_nettype wire

// ===== test/tb_top.sv =====
// testbench: randomised and directed checking of the domain colouring pixel unit
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import dcp_pkg::*;

    localparam int LATENCY = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam logic [PADDR_W-1:0] ADDR_CONTOUR_SEL = PADDR_W'(0);
    localparam logic [PADDR_W-1:0] ADDR_INV_DENSITY = PADDR_W'(4);

    logic [16:0] exp2_lut [0:256];
    logic [16:0] ln_lut [0:256];

    function automatic logic [16:0] round_q30(input logic [63:0] v);
        logic [63:0] r;
        r = (v + 64'd8192) >> 14;
        return r[16:0];
    endfunction

    function automatic void fill_luts();
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] u;
        logic [63:0] u2;
        for (int k = 0; k <= 256; k++)
        begin
            x = (64'(k) * 64'd744261118) / 64'd256;
            term = 64'd1 << 30;
            acc = 64'd1 << 30;
            for (int n = 1; n <= 20; n++)
            begin
                term = ((term * x) >> 30) / 64'(n);
                if (n % 2 == 1)
                    acc = acc - term;
                else
                    acc = acc + term;
            end
            exp2_lut[k] = round_q30(acc);
            u = (64'(k) << 30) / (64'd512 + 64'(k));
            u2 = (u * u) >> 30;
            term = u;
            acc = u;
            for (int n = 3; n <= 41; n += 2)
            begin
                term = (term * u2) >> 30;
                acc = acc + term / 64'(n);
            end
            ln_lut[k] = round_q30(acc << 1);
        end
    endfunction

    function automatic logic [31:0] apply_shade(input logic [31:0] v, input logic [15:0] fr);
        logic [31:0] factor;
        logic [63:0] p;
        factor = 32'd52429 + ((32'd13107 * 32'(fr)) >> 16);
        p = (64'(v) * 64'(factor)) >> 16;
        return p[31:0];
    endfunction

    function automatic color_t colour_of(input sample_t s, input logic [1:0] mode,
                                         input logic [31:0] dens);
        color_t c;
        logic [15:0] h;
        logic [31:0] mag;
        logic [31:0] ip;
        logic [31:0] i;
        logic [31:0] t;
        logic [31:0] e2;
        logic [31:0] v;
        logic [31:0] msb;
        logic [63:0] mant;
        logic [31:0] li;
        logic [31:0] lt;
        logic [31:0] lv;
        logic [63:0] lnq;
        logic [63:0] prod;
        logic [31:0] seg;
        logic [31:0] sector;
        logic [31:0] f;
        logic [31:0] w;
        logic [63:0] cb;
        logic [63:0] xq;
        logic [63:0] xb;
        c = '0;
        h = s.phase_turns;
        mag = s.magnitude;
        if (mag == 0)
            return c;
        ip = mag >> 16;
        i = (mag & 32'hFFFF) >> 8;
        t = mag & 32'hFF;
        e2 = 32'(exp2_lut[i]) - (((32'(exp2_lut[i]) - 32'(exp2_lut[i + 1])) * t) >> 8);
        v = 32'd65536 - ((ip >= 32) ? 32'd0 : (e2 >> ip));
        if (mode[0])
        begin
            msb = 31;
            while (mag[msb] == 1'b0)
                msb--;
            mant = (64'(mag) << (31 - msb)) & 64'h7FFF_FFFF;
            li = 32'(mant >> 23);
            lt = 32'(mant) & 32'h7F_FFFF;
            lv = 32'(ln_lut[li]) + 32'(((64'(32'(ln_lut[li + 1]) - 32'(ln_lut[li]))) * 64'(lt)) >> 23);
            lnq = (64'(signed'(msb)) - 64'sd16) * 64'sd45426 + 64'(lv);
            prod = lnq * 64'(dens);
            v = apply_shade(v, prod[31:16]);
        end
        if (mode[1])
            v = apply_shade(v, 16'(32'(h) * 12));
        seg = 32'(h) * 6;
        sector = seg >> 16;
        f = seg & 32'hFFFF;
        w = sector[0] ? 32'd65536 - f : f;
        cb = (64'(v) * 255) >> 16;
        xq = (64'(v) * 64'(w)) >> 16;
        xb = ((xq & 64'hFFFF_FFFF) * 255) >> 16;
        case (sector)
            0: begin c.red = cb[7:0]; c.green = xb[7:0]; end
            1: begin c.red = xb[7:0]; c.green = cb[7:0]; end
            2: begin c.green = cb[7:0]; c.blue = xb[7:0]; end
            3: begin c.green = xb[7:0]; c.blue = cb[7:0]; end
            4: begin c.red = xb[7:0]; c.blue = cb[7:0]; end
            default: begin c.red = cb[7:0]; c.blue = xb[7:0]; end
        endcase
        return c;
    endfunction

    class colour_scoreboard;
        color_t pending[$];
        int errors;
        int checked;
        logic [1:0] mode;
        logic [31:0] dens;

        function void note_sample(sample_t s);
            pending.push_back(colour_of(s, mode, dens));
        endfunction

        function void check_colour(color_t got);
            color_t want;
            if (pending.size() == 0)
            begin
                $error("unexpected word %h", got);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.red !== want.red)
            begin
                $error("red expected %0d actual %0d", want.red, got.red);
                errors++;
            end
            if (got.green !== want.green)
            begin
                $error("green expected %0d actual %0d", want.green, got.green);
                errors++;
            end
            if (got.blue !== want.blue)
            begin
                $error("blue expected %0d actual %0d", want.blue, got.blue);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic sample_valid;
    sample_t sample;
    logic sample_stall;
    logic color_valid;
    color_t color;
    logic color_stall;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    colour_scoreboard board;
    int idle_cycles;
    bit gaps_on;
    bit long_hold;
    int sent;

    domain_coloring_pixel_unit i_dut (
        .clk(clk), .rst_n(rst_n),
        .sample_valid(sample_valid), .sample(sample), .sample_stall(sample_stall),
        .color_valid(color_valid), .color(color), .color_stall(color_stall),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk)
    begin
        if (rst_n && color_valid && !color_stall)
            board.check_colour(color);
        if (rst_n && ((sample_valid && !sample_stall) || (color_valid && !color_stall)))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // receiver back-pressure
    initial
    begin
        int n;
        color_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                color_stall <= 1'b1;
                repeat (300) @(negedge clk);
                long_hold = 1'b0;
                color_stall <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                n = $urandom_range(1, 17);
                color_stall <= 1'b1;
                repeat (n) @(negedge clk);
                color_stall <= 1'b0;
            end
        end
    end

    task automatic write_reg(input logic [PADDR_W-1:0] a, input logic [31:0] d);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (a == ADDR_CONTOUR_SEL)
            board.mode = d[1:0];
        else
            board.dens = d;
    endtask

    task automatic send_sample(input sample_t s);
        int n;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 17);
            sample_valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample <= s;
        @(posedge clk);
        while (sample_stall)
            @(posedge clk);
        board.note_sample(s);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        sample_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (LATENCY + 4) @(negedge clk);
    endtask

    function automatic sample_t random_sample();
        sample_t s;
        s.phase_turns = 16'($urandom());
        case ($urandom_range(0, 3))
            0: s.magnitude = $urandom();
            1: s.magnitude = $urandom_range(0, 32'h0004_0000);
            2: s.magnitude = $urandom() >> $urandom_range(0, 31);
            default: s.magnitude = $urandom_range(0, 3) == 0 ? 32'd0 : $urandom_range(1, 255);
        endcase
        return s;
    endfunction

    initial
    begin
        logic [31:0] dens_set [5];
        logic [31:0] mags [8];
        logic [15:0] phs [6];
        dens_set = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd655360, 32'd6554};
        mags = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0020_0000,
                 32'h0000_8000, 32'h0000_FFFF, 32'h8000_0000};
        phs = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h2AAB, 16'h5555};
        fill_luts();
        board = new();
        board.mode = CONTOUR_SEL_RESET;
        board.dens = INV_DENSITY_RESET;
        rst_n = 1'b0;
        sample_valid = 1'b0;
        sample = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_cycles = 0;
        gaps_on = 1'b0;
        long_hold = 1'b0;
        sent = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners, every mode
        for (int m = 0; m < 4; m++)
        begin
            write_reg(ADDR_CONTOUR_SEL, 32'(m));
            for (int k = 0; k < 6; k++)
                send_sample('{phase_turns: phs[k], magnitude: mags[(k + m * 2) % 8]});
            drain();
        end

        gaps_on = 1'b1;
        for (int p = 0; p < 10; p++)
        begin
            write_reg(ADDR_CONTOUR_SEL, {$urandom()} % 4 | (p < 4 ? 3 : 0));
            write_reg(ADDR_INV_DENSITY, p < 5 ? dens_set[p] : $urandom());
            if (p == 3)
                long_hold = 1'b1;
            if (p == 9)
                gaps_on = 1'b0;
            for (int k = 0; k < 160; k++)
                send_sample(random_sample());
            drain();
        end
        write_reg(ADDR_CONTOUR_SEL, 32'hFFFF_FFFC);
        board.mode = 2'd0;
        send_sample('{phase_turns: 16'h1234, magnitude: 32'h0003_0000});
        drain();

        $display("covered %0d samples, %0d colours checked, all contour modes and density corners",
                 sent, board.checked);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
design/dcp_pkg.sv
design/dcp_core.sv
design/domain_coloring_pixel_unit.sv
design/dcp_checker.sv
test/tb_top.sv
